FILE: rtl/pce_pkg.sv
// ============================================================================
// pce_pkg - shared types and constants for the correlation engine
// Widths of the running sums, the serial product and root datapaths, and the
// state types of the sequencers.
// ============================================================================
package pce_pkg;

    // Set size and sample precision
    localparam int MAX_SAMPLES = 16;
    localparam int SAMPLE_BITS = 16;

    // Fixed port widths
    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int USED_W = 5;

    // Derived widths
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int LOG_MAX = $clog2(MAX_SAMPLES);
    localparam int LIN_W   = SAMPLE_BITS + LOG_MAX;        // Sv, Sc
    localparam int SQ_W    = 2 * SAMPLE_BITS + LOG_MAX;    // Svv, Scc, Svc
    localparam int MC_W    = 2 * SAMPLE_BITS;              // one sample product
    localparam int STEP_W  = $clog2(SAMPLE_BITS);
    localparam int NS_W    = CNT_W + SQ_W;                 // n * Svv
    localparam int D_W     = 2 * LIN_W;                    // variance terms
    localparam int P_W     = 2 * D_W;                      // Dv * Dc
    localparam int S_W     = D_W;                          // square root
    localparam int R_W     = S_W + 3;                      // root remainder
    localparam int DR_W    = S_W + 1;                      // divide remainder, |N|
    localparam int IT_W    = $clog2(D_W);

    // Q1.15 saturation limits
    localparam logic [OUT_W-1:0] Q_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] Q_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

    // Running sums handed from the accumulator
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [LIN_W-1:0] sv;
        logic [LIN_W-1:0] sc;
        logic [SQ_W-1:0]  svv;
        logic [SQ_W-1:0]  scc;
        logic [SQ_W-1:0]  svc;
        logic             drop;
    } t_sums;

    // Centered moments handed to the root and divide unit
    typedef struct packed {
        logic            degen;
        logic            neg;
        logic [DR_W-1:0] nmag;
        logic [P_W-1:0]  prod;
    } t_moments;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_MOM,
        ST_RATIO,
        ST_HOLD
    } t_top_state;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_MUL,
        MS_DIFF,
        MS_PROD,
        MS_DONE
    } t_mom_state;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_ROOT,
        RS_DIV,
        RS_DONE
    } t_rat_state;

endpackage

FILE: rtl/pce_accum.sv
// ============================================================================
// pce_accum - running sums of samples, squares and cross products
// Each sample is multiplied bit-serially, one multiplier bit per cycle, into
// the three square and cross sums.
// ============================================================================
module pce_accum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_clear,
    input  logic [pce_pkg::SAMPLE_BITS-1:0] i_volt,
    input  logic [pce_pkg::SAMPLE_BITS-1:0] i_curr,
    output logic                           o_busy,
    output pce_pkg::t_sums                 o_sums
);
    import pce_pkg::*;

    logic [CNT_W-1:0]       r_cnt;
    logic [LIN_W-1:0]       r_sv;
    logic [LIN_W-1:0]       r_sc;
    logic [SQ_W-1:0]        r_svv;
    logic [SQ_W-1:0]        r_scc;
    logic [SQ_W-1:0]        r_svc;
    logic                   r_drop;
    logic                   r_busy;
    logic [STEP_W-1:0]      r_step;
    logic [SAMPLE_BITS-1:0] r_mp_v;
    logic [SAMPLE_BITS-1:0] r_mp_c;
    logic [MC_W-1:0]        r_mc_v;
    logic [MC_W-1:0]        r_mc_c;
    logic                   w_take;

    assign w_take = r_cnt < CNT_W'(MAX_SAMPLES);

    // Sums, count and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cnt  <= '0;
            r_sv   <= '0;
            r_sc   <= '0;
            r_svv  <= '0;
            r_scc  <= '0;
            r_svc  <= '0;
            r_drop <= 1'b0;
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            if (w_take) begin
                r_cnt  <= r_cnt + 1'b1;
                r_sv   <= r_sv + LIN_W'(i_volt);
                r_sc   <= r_sc + LIN_W'(i_curr);
                r_busy <= 1'b1;
                r_step <= '0;
            end else begin
                r_drop <= 1'b1;
            end
        end else if (r_busy) begin
            // one shift-add step of v*v, c*c and v*c
            if (r_mp_v[0]) begin
                r_svv <= r_svv + SQ_W'(r_mc_v);
                r_svc <= r_svc + SQ_W'(r_mc_c);
            end
            if (r_mp_c[0]) begin
                r_scc <= r_scc + SQ_W'(r_mc_c);
            end
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(SAMPLE_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Multiplier and multiplicand shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mp_v <= i_volt;
            r_mp_c <= i_curr;
            r_mc_v <= MC_W'(i_volt);
            r_mc_c <= MC_W'(i_curr);
        end else if (r_busy) begin
            r_mp_v <= r_mp_v >> 1;
            r_mp_c <= r_mp_c >> 1;
            r_mc_v <= r_mc_v << 1;
            r_mc_c <= r_mc_c << 1;
        end
    end

    assign o_busy = r_busy;

    always_comb begin
        o_sums.cnt  = r_cnt;
        o_sums.sv   = r_sv;
        o_sums.sc   = r_sc;
        o_sums.svv  = r_svv;
        o_sums.scc  = r_scc;
        o_sums.svc  = r_svc;
        o_sums.drop = r_drop;
    end

endmodule

FILE: rtl/pce_moments.sv
// ============================================================================
// pce_moments - centered moment terms and their product
// Forms n*Svv - Sv^2, n*Scc - Sc^2, n*Svc - Sv*Sc with bit-serial multiplies,
// then the product of the nonzero variance terms, one multiplier bit per cycle.
// ============================================================================
module pce_moments (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pce_pkg::t_sums    i_sums,
    output logic              o_done,
    output pce_pkg::t_moments o_mom
);
    import pce_pkg::*;

    t_mom_state r_state;
    t_mom_state n_state;

    logic [IT_W-1:0]  r_it;
    logic [LIN_W-1:0] r_mp_v;
    logic [LIN_W-1:0] r_mp_c;
    logic [D_W-1:0]   r_mc_v;
    logic [D_W-1:0]   r_mc_c;
    logic [D_W-1:0]   r_a_vv;
    logic [D_W-1:0]   r_a_cc;
    logic [D_W-1:0]   r_a_vc;
    logic [CNT_W-1:0] r_mp_n;
    logic [NS_W-1:0]  r_mc_nvv;
    logic [NS_W-1:0]  r_mc_ncc;
    logic [NS_W-1:0]  r_mc_nvc;
    logic [NS_W-1:0]  r_n_vv;
    logic [NS_W-1:0]  r_n_cc;
    logic [NS_W-1:0]  r_n_vc;
    logic [D_W-1:0]   r_pm;
    logic [P_W-1:0]   r_pc;
    logic [P_W-1:0]   r_prod;
    logic             r_neg;
    logic [DR_W-1:0]  r_nmag;
    logic             r_degen;

    logic [D_W-1:0]   w_dv;
    logic [D_W-1:0]   w_dc;
    logic [NS_W:0]    w_num;
    logic [NS_W:0]    w_abs;
    logic             w_degen;

    // Differences of the products; true values fit D_W bits and |N| fits DR_W
    assign w_dv    = D_W'(r_n_vv - NS_W'(r_a_vv));
    assign w_dc    = D_W'(r_n_cc - NS_W'(r_a_cc));
    assign w_num   = {1'b0, r_n_vc} - (NS_W + 1)'(r_a_vc);
    assign w_abs   = w_num[NS_W] ? ((NS_W + 1)'(0) - w_num) : w_num;
    assign w_degen = (w_dv == '0) || (w_dc == '0);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MS_IDLE: if (i_start) n_state = MS_MUL;
            MS_MUL:  if (r_it == IT_W'(LIN_W - 1)) n_state = MS_DIFF;
            MS_DIFF: n_state = w_degen ? MS_DONE : MS_PROD;
            MS_PROD: if (r_it == IT_W'(D_W - 1)) n_state = MS_DONE;
            MS_DONE: n_state = MS_IDLE;
            default: n_state = MS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_done = 1'b0;
        unique case (r_state)
            MS_DONE: o_done = 1'b1;
            default: o_done = 1'b0;
        endcase
    end

    // Serial datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            MS_IDLE: begin
                if (i_start) begin
                    r_it     <= '0;
                    r_mp_v   <= i_sums.sv;
                    r_mp_c   <= i_sums.sc;
                    r_mc_v   <= D_W'(i_sums.sv);
                    r_mc_c   <= D_W'(i_sums.sc);
                    r_a_vv   <= '0;
                    r_a_cc   <= '0;
                    r_a_vc   <= '0;
                    r_mp_n   <= i_sums.cnt;
                    r_mc_nvv <= NS_W'(i_sums.svv);
                    r_mc_ncc <= NS_W'(i_sums.scc);
                    r_mc_nvc <= NS_W'(i_sums.svc);
                    r_n_vv   <= '0;
                    r_n_cc   <= '0;
                    r_n_vc   <= '0;
                end
            end
            MS_MUL: begin
                // Sv*Sv, Sc*Sc, Sv*Sc and n times Svv, Scc and Svc
                if (r_mp_v[0]) begin
                    r_a_vv <= r_a_vv + r_mc_v;
                    r_a_vc <= r_a_vc + r_mc_c;
                end
                if (r_mp_c[0]) begin
                    r_a_cc <= r_a_cc + r_mc_c;
                end
                if (r_mp_n[0]) begin
                    r_n_vv <= r_n_vv + r_mc_nvv;
                    r_n_cc <= r_n_cc + r_mc_ncc;
                    r_n_vc <= r_n_vc + r_mc_nvc;
                end
                r_mp_v   <= r_mp_v >> 1;
                r_mp_c   <= r_mp_c >> 1;
                r_mc_v   <= r_mc_v << 1;
                r_mc_c   <= r_mc_c << 1;
                r_mp_n   <= r_mp_n >> 1;
                r_mc_nvv <= r_mc_nvv << 1;
                r_mc_ncc <= r_mc_ncc << 1;
                r_mc_nvc <= r_mc_nvc << 1;
                r_it     <= r_it + 1'b1;
            end
            MS_DIFF: begin
                r_degen <= w_degen;
                r_neg   <= w_num[NS_W];
                r_nmag  <= DR_W'(w_abs);
                r_pm    <= w_dv;
                r_pc    <= P_W'(w_dc);
                r_prod  <= '0;
                r_it    <= '0;
            end
            MS_PROD: begin
                // Dv * Dc, one bit of Dv per cycle
                if (r_pm[0]) begin
                    r_prod <= r_prod + r_pc;
                end
                r_pm <= r_pm >> 1;
                r_pc <= r_pc << 1;
                r_it <= r_it + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_mom.degen = r_degen;
        o_mom.neg   = r_neg;
        o_mom.nmag  = r_nmag;
        o_mom.prod  = r_prod;
    end

endmodule

FILE: rtl/pce_ratio.sv
// ============================================================================
// pce_ratio - square root and fractional divide
// Restoring square root of Dv*Dc, two radicand bits per cycle, then restoring
// division of |N| by the root, one quotient bit per cycle, with Q1.15
// saturation and sign.
// ============================================================================
module pce_ratio (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  pce_pkg::t_moments        i_mom,
    output logic                     o_done,
    output logic [pce_pkg::OUT_W-1:0] o_corr
);
    import pce_pkg::*;

    t_rat_state r_state;
    t_rat_state n_state;

    logic [IT_W-1:0]  r_it;
    logic [P_W-1:0]   r_rad;
    logic [R_W-1:0]   r_rem;
    logic [S_W-1:0]   r_root;
    logic [DR_W-1:0]  r_drem;
    logic [OUT_W-1:0] r_q;
    logic             r_neg;

    logic [R_W-1:0]   w_rt;
    logic [R_W-1:0]   w_trial;
    logic             w_rge;
    logic [DR_W:0]    w_dt;
    logic [DR_W:0]    w_den;
    logic             w_dge;
    logic [OUT_W-1:0] w_mag;

    // Root step: bring down two radicand bits, try root*4+1
    assign w_rt    = {r_rem[R_W-3:0], r_rad[P_W-1:P_W-2]};
    assign w_trial = R_W'({r_root, 2'b01});
    assign w_rge   = w_rt >= w_trial;

    // Divide step: the first step compares |N| itself
    assign w_dt  = (r_it == '0) ? {1'b0, r_drem} : {r_drem, 1'b0};
    assign w_den = (DR_W + 1)'(r_root);
    assign w_dge = w_dt >= w_den;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RS_IDLE: if (i_start) n_state = RS_ROOT;
            RS_ROOT: if (r_it == IT_W'(S_W - 1)) n_state = RS_DIV;
            RS_DIV:  if (r_it == IT_W'(OUT_W - 1)) n_state = RS_DONE;
            RS_DONE: n_state = RS_IDLE;
            default: n_state = RS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_done = 1'b0;
        unique case (r_state)
            RS_DONE: o_done = 1'b1;
            default: o_done = 1'b0;
        endcase
    end

    // Serial datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            RS_IDLE: begin
                if (i_start) begin
                    r_it   <= '0;
                    r_rad  <= i_mom.prod;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_drem <= i_mom.nmag;
                    r_neg  <= i_mom.neg;
                    r_q    <= '0;
                end
            end
            RS_ROOT: begin
                r_rad  <= r_rad << 2;
                r_rem  <= w_rge ? (w_rt - w_trial) : w_rt;
                r_root <= {r_root[S_W-2:0], w_rge};
                r_it   <= (r_it == IT_W'(S_W - 1)) ? '0 : r_it + 1'b1;
            end
            RS_DIV: begin
                r_drem <= DR_W'(w_dge ? (w_dt - w_den) : w_dt);
                r_q    <= {r_q[OUT_W-2:0], w_dge};
                r_it   <= r_it + 1'b1;
            end
            default: ;
        endcase
    end

    // Saturate and apply the sign
    always_comb begin
        if (r_neg) begin
            w_mag  = (r_q > Q_NEG_MAG) ? Q_NEG_MAG : r_q;
            o_corr = OUT_W'(0) - w_mag;
        end else begin
            w_mag  = (r_q > Q_POS_MAX) ? Q_POS_MAX : r_q;
            o_corr = w_mag;
        end
    end

endmodule

FILE: rtl/pearson_correlation_engine_core.sv
// ============================================================================
// pearson_correlation_engine_core - Pearson correlation of paired samples
// Accumulates voltage/current pairs and, on the sample marked last, clears its
// sums and emits the correlation coefficient in signed Q1.15.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   sample  | in        | i_valid / o_stall   | voltage, current, last flag
//   result  | out       | o_valid / i_stall   | correlation, flags, sample count
//
// o_stall stays high while a sample is multiplied serially; a dropped sample skips it.
// A last sample then runs the serial moment products, the root and the divide;
// zero variance skips the variance product, the root and the divide.
// Reset is synchronous and clears the sums, count and drop flag.
// One result register holds a finished beat while i_stall is high; samples
// are still taken meanwhile, and a later result waits until the slot is free.
// ============================================================================
module pearson_correlation_engine_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [pce_pkg::IN_W-1:0]  i_voltage_code,
    input  logic [pce_pkg::IN_W-1:0]  i_current_code,
    input  logic                      i_last_sample,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [pce_pkg::OUT_W-1:0] o_correlation_q15,
    output logic                      o_degenerate,
    output logic                      o_overflowed,
    output logic [pce_pkg::USED_W-1:0] o_samples_used
);
    import pce_pkg::*;

    t_top_state r_state;
    t_top_state n_state;

    logic              r_last;
    logic [USED_W-1:0] r_used;
    logic              r_ovf;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_corr;
    logic              r_degen;
    logic [USED_W-1:0] r_out_used;
    logic              r_out_ovf;

    logic              w_acc_start;
    logic              w_acc_clear;
    logic              w_acc_busy;
    t_sums             w_sums;
    logic              w_mom_start;
    logic              w_mom_done;
    t_moments          w_mom;
    logic              w_rat_start;
    logic              w_rat_done;
    logic [OUT_W-1:0]  w_rat_corr;
    logic              w_out_free;
    logic              w_out_load;

    assign w_out_free = !r_out_valid || !i_stall;

    pce_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc_start),
        .i_clear (w_acc_clear),
        .i_volt  (SAMPLE_BITS'(i_voltage_code)),
        .i_curr  (SAMPLE_BITS'(i_current_code)),
        .o_busy  (w_acc_busy),
        .o_sums  (w_sums)
    );

    pce_moments u_moments (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mom_start),
        .i_sums  (w_sums),
        .o_done  (w_mom_done),
        .o_mom   (w_mom)
    );

    pce_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rat_start),
        .i_mom   (w_mom),
        .o_done  (w_rat_done),
        .o_corr  (w_rat_corr)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_MAC;
            ST_MAC:   if (!w_acc_busy) n_state = r_last ? ST_MOM : ST_IDLE;
            ST_MOM:   if (w_mom_done) n_state = w_mom.degen ? ST_HOLD : ST_RATIO;
            ST_RATIO: if (w_rat_done) n_state = ST_HOLD;
            ST_HOLD:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_stall     = 1'b1;
        w_acc_start = 1'b0;
        w_acc_clear = 1'b0;
        w_mom_start = 1'b0;
        w_rat_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall     = 1'b0;
                w_acc_start = i_valid;
            end
            ST_MAC: begin
                w_mom_start = !w_acc_busy && r_last;
                w_acc_clear = !w_acc_busy && r_last;
            end
            ST_MOM:   w_rat_start = w_mom_done && !w_mom.degen;
            ST_RATIO: ;
            ST_HOLD:  w_out_load = w_out_free;
            default:  ;
        endcase
    end

    // Per-set bookkeeping, captured before the sums clear
    always_ff @(posedge i_clk) begin
        if (w_acc_start) begin
            r_last <= i_last_sample;
        end
        if (w_mom_start) begin
            r_used <= USED_W'(w_sums.cnt);
            r_ovf  <= w_sums.drop;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_corr     <= w_mom.degen ? '0 : w_rat_corr;
            r_degen    <= w_mom.degen;
            r_out_used <= r_used;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_correlation_q15 = r_corr;
    assign o_degenerate      = r_degen;
    assign o_overflowed      = r_out_ovf;
    assign o_samples_used    = r_out_used;

endmodule

FILE: rtl/pce_checker.sv
// ============================================================================
// pce_checker - port-level checks for the correlation engine
// Watches the top-level ports only; attached by a bind statement below.
// ============================================================================
module pce_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [pce_pkg::OUT_W-1:0]  o_correlation_q15,
    input logic                       o_degenerate,
    input logic                       o_overflowed,
    input logic [pce_pkg::USED_W-1:0] o_samples_used
);
    import pce_pkg::*;

    // A stalled result beat stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_correlation_q15) && $stable(o_degenerate)
            && $stable(o_overflowed) && $stable(o_samples_used))
        else $error("result payload changed while stalled");

    // Zero variance forces a zero coefficient
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_correlation_q15 == '0)
        else $error("degenerate result with nonzero coefficient");

    // Dropped samples only happen once the set is full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflowed |-> o_samples_used == USED_W'(MAX_SAMPLES))
        else $error("overflow flagged on a set that was not full");

    // A new result only follows a busy period of the engine
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without the engine being busy");

endmodule

bind pearson_correlation_engine_core pce_checker u_pce_checker (.*);
